@@ sv/assert_macros.svh @@
// Assertion macros used by ibtt_ctrl of the tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ sv/ibtt_pkg.sv @@
// Shared types, constants and the CORDIC angle table of the tilt tracker
package ibtt_pkg;

   localparam int ATAN_ENTRIES     = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int STEP_W           = $clog2(ATAN_ENTRIES);
   localparam int BIAS_SLOTS       = 6;

   localparam int CW  = 36;
   localparam int AW  = 34;
   localparam int MAW = 25;
   localparam int MBW = 32;
   localparam int PW  = MAW + MBW;
   localparam int ACW = 66;
   localparam int DW  = 20;

   localparam logic signed [MBW-1:0] HALF_SQRT2_Q16 = 32'sd46341;
   localparam logic signed [MBW-1:0] PI_Q29         = 32'sd1686629713;
   localparam logic signed [AW-1:0]  QUARTER_TURN   = 34'sd1073741824;

   localparam logic [15:0]        BIAS_WEIGHT_RST  = 16'd3277;
   localparam logic [15:0]        ANGLE_WEIGHT_RST = 16'd3277;
   localparam logic signed [15:0] ANGLE_OFFSET_RST = 16'sd106;

   typedef enum logic [1:0] {
      CSR_BIAS_WEIGHT  = 2'd0,
      CSR_ANGLE_WEIGHT = 2'd1,
      CSR_ANGLE_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_YMUL,
      OP_PRE,
      OP_ITER,
      OP_PLO,
      OP_PHI,
      OP_PSUM,
      OP_ANG,
      OP_TMUL,
      OP_TUPD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [STEP_W-1:0] step;
      logic              bias_mul;
      logic              bias_upd;
      logic [1:0]        axis;
   } cmd_type;

   function automatic logic signed [AW-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [AW-1:0] v;
      case (idx)
         5'd0:    v = 34'sd536870912;
         5'd1:    v = 34'sd316933406;
         5'd2:    v = 34'sd167458907;
         5'd3:    v = 34'sd85004756;
         5'd4:    v = 34'sd42667331;
         5'd5:    v = 34'sd21354465;
         5'd6:    v = 34'sd10679838;
         5'd7:    v = 34'sd5340245;
         5'd8:    v = 34'sd2670163;
         5'd9:    v = 34'sd1335087;
         5'd10:   v = 34'sd667544;
         5'd11:   v = 34'sd333772;
         5'd12:   v = 34'sd166886;
         5'd13:   v = 34'sd83443;
         5'd14:   v = 34'sd41722;
         5'd15:   v = 34'sd20861;
         5'd16:   v = 34'sd10430;
         5'd17:   v = 34'sd5215;
         5'd18:   v = 34'sd2608;
         5'd19:   v = 34'sd1304;
         5'd20:   v = 34'sd652;
         5'd21:   v = 34'sd326;
         5'd22:   v = 34'sd163;
         5'd23:   v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/ibtt_ctrl.sv @@
// Sequencer of the tilt tracker: handshakes, CORDIC step count, datapath commands
`include "assert_macros.svh"

module ibtt_ctrl #(
   parameter int CORDIC_STEPS = ibtt_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_func,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ibtt_pkg::cmd_type cmd
);
   import ibtt_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YMUL,
      ST_PRE,
      ST_ITER,
      ST_PLO,
      ST_PHI,
      ST_PSUM,
      ST_ANG,
      ST_TMUL,
      ST_TUPD,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              ready_ff, ready_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      cmd.bias_mul = 1'b0;
      cmd.bias_upd = 1'b0;
      cmd.axis     = step_ff[2:1];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               ready_in = 1'b0;
               state_in = req_func ? ST_YMUL : ST_EMIT;
            end
         end
         ST_YMUL: begin
            cmd.op   = OP_YMUL;
            state_in = ST_PRE;
         end
         ST_PRE: begin
            cmd.op   = OP_PRE;
            step_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.op = OP_ITER;
            if (step_ff < STEP_W'(BIAS_SLOTS)) begin
               cmd.bias_mul = !step_ff[0];
               cmd.bias_upd = step_ff[0];
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_PLO;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PLO: begin
            cmd.op   = OP_PLO;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            cmd.op   = OP_PHI;
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            cmd.op   = OP_PSUM;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.op   = OP_ANG;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            cmd.op   = OP_TMUL;
            state_in = ST_TUPD;
         end
         ST_TUPD: begin
            cmd.op   = OP_TUPD;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               ready_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_IMPL(a_ready_only_idle, clock, reset, ready_ff, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_cal_starts, clock, reset, req_valid && ready_ff && req_func, state_ff == ST_YMUL)
   `ASSERT_NEXT(a_emit_shows, clock, reset, state_ff == ST_EMIT && out_free, rsp_valid_ff && ready_ff)
   `ASSERT_IMPL(a_step_range, clock, reset, state_ff == ST_ITER, step_ff <= STEP_LAST)

endmodule

@@ sv/ibtt_datapath.sv @@
// Datapath of the tilt tracker: bias store, shared multiplier, CORDIC, tilt blend, result beat
module ibtt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ibtt_pkg::cmd_type      cmd,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   req_func,
   input  logic signed [15:0]     req_accel_x,
   input  logic signed [15:0]     req_accel_y,
   input  logic signed [15:0]     req_accel_z,
   input  logic signed [15:0]     req_gyro_x,
   input  logic signed [15:0]     req_gyro_y,
   input  logic signed [15:0]     req_gyro_z,
   output logic signed [15:0]     rsp_rate_x,
   output logic signed [15:0]     rsp_rate_y,
   output logic signed [15:0]     rsp_rate_z,
   output logic signed [15:0]     rsp_acc_out_x,
   output logic signed [15:0]     rsp_acc_out_y,
   output logic signed [15:0]     rsp_acc_out_z,
   output logic signed [15:0]     rsp_tilt
);
   import ibtt_pkg::*;

   localparam logic signed [PW-1:0]  RND16 = PW'(32768);
   localparam logic signed [ACW-1:0] RND48 = ACW'(1) << 47;
   localparam logic signed [PW:0]    MAX24 = (PW+1)'(8388607);
   localparam logic signed [PW:0]    MIN24 = -(PW+1)'(8388608);

   function automatic logic signed [15:0] sat16(input logic signed [PW:0] v);
      logic signed [15:0] r;
      if (v > (PW+1)'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -(PW+1)'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic [15:0]        bias_weight_ff;
   logic [15:0]        angle_weight_ff;
   logic signed [15:0] angle_offset_ff;

   logic signed [23:0] bias_ff [3];
   logic signed [15:0] tilt_ff, tilt_in;

   logic               func_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] g_ff [3];

   logic signed [CW-1:0]  x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [AW-1:0]  ang_ff, ang_in;
   logic                  zero_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [ACW-1:0] prod_acc_ff;
   logic signed [DW-1:0]  diff_ff;

   logic signed [MAW-1:0] mul_a;
   logic signed [MBW-1:0] mul_b;
   logic signed [PW-1:0]  mul_p;
   logic signed [16:0]    axy;
   logic signed [24:0]    bias_diff;
   logic signed [PW:0]    bias_sum;
   logic signed [23:0]    bias_new;
   logic signed [PW:0]    tilt_sum;
   logic signed [15:0]    ax_neg;

   logic signed [24:0]    bt [3];
   logic signed [15:0]    rate_w [3];

   logic signed [15:0]    out_rate_ff [3];
   logic signed [15:0]    out_acc_ff [3];
   logic signed [15:0]    out_tilt_ff;

   assign axy       = 17'(ax_ff) + 17'(ay_ff);
   assign bias_diff = 25'(signed'({g_ff[cmd.axis], 8'h00})) - 25'(bias_ff[cmd.axis]);
   assign ax_neg    = (req_accel_x == 16'sh8000) ? 16'sh7FFF : -req_accel_x;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.bias_mul) begin
         mul_a = bias_diff;
         mul_b = MBW'(bias_weight_ff);
      end else begin
         case (cmd.op)
            OP_YMUL: begin
               mul_a = MAW'(axy);
               mul_b = HALF_SQRT2_Q16;
            end
            OP_PLO: begin
               mul_a = {{(MAW-17){1'b0}}, ang_ff[16:0]};
               mul_b = PI_Q29;
            end
            OP_PHI: begin
               mul_a = MAW'(signed'(ang_ff[AW-1:17]));
               mul_b = PI_Q29;
            end
            OP_TMUL: begin
               mul_a = MAW'(diff_ff);
               mul_b = MBW'(angle_weight_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      bias_sum = (PW+1)'(bias_ff[cmd.axis]) + (PW+1)'((prod_ff + RND16) >>> 16);
      if (bias_sum > MAX24) begin
         bias_new = 24'sh7FFFFF;
      end else if (bias_sum < MIN24) begin
         bias_new = 24'sh800000;
      end else begin
         bias_new = bias_sum[23:0];
      end
      tilt_sum = (PW+1)'(tilt_ff) + (PW+1)'((prod_ff + RND16) >>> 16);
      tilt_in  = sat16(tilt_sum);
   end

   always_comb begin
      xs     = x_ff >>> cmd.step;
      ys     = y_ff >>> cmd.step;
      x_in   = x_ff;
      y_in   = y_ff;
      ang_in = ang_ff;
      if (cmd.op == OP_PRE) begin
         ang_in = '0;
         if (x_ff < 0) begin
            if (y_ff >= 0) begin
               x_in   = y_ff;
               y_in   = -x_ff;
               ang_in = QUARTER_TURN;
            end else begin
               x_in   = -y_ff;
               y_in   = x_ff;
               ang_in = -QUARTER_TURN;
            end
         end
      end else begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            if (!zero_ff) begin
               ang_in = ang_ff + atan_entry(cmd.step);
            end
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            if (!zero_ff) begin
               ang_in = ang_ff - atan_entry(cmd.step);
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bt[k] = (25'(bias_ff[k]) + (bias_ff[k][23] ? 25'sd255 : 25'sd0)) >>> 8;
         if (func_ff) begin
            rate_w[k] = g_ff[k];
         end else begin
            rate_w[k] = sat16((PW+1)'(g_ff[k]) - (PW+1)'(bt[k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_weight_ff  <= BIAS_WEIGHT_RST;
         angle_weight_ff <= ANGLE_WEIGHT_RST;
         angle_offset_ff <= ANGLE_OFFSET_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIAS_WEIGHT:  bias_weight_ff  <= csr_wdata;
            CSR_ANGLE_WEIGHT: angle_weight_ff <= csr_wdata;
            CSR_ANGLE_OFFSET: angle_offset_ff <= signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff[0] <= '0;
         bias_ff[1] <= '0;
         bias_ff[2] <= '0;
         tilt_ff    <= '0;
      end else begin
         if (cmd.bias_upd) begin
            bias_ff[cmd.axis] <= bias_new;
         end
         if (cmd.op == OP_TUPD) begin
            tilt_ff <= tilt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bias_mul) begin
         prod_ff <= mul_p;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            func_ff <= req_func;
            ax_ff   <= ax_neg;
            ay_ff   <= req_accel_y;
            az_ff   <= req_accel_z;
            g_ff[0] <= req_gyro_x;
            g_ff[1] <= req_gyro_y;
            g_ff[2] <= req_gyro_z;
         end
         OP_YMUL: begin
            x_ff <= CW'(signed'({az_ff, 16'h0000}));
            y_ff <= CW'(mul_p);
         end
         OP_PRE: begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            ang_ff  <= ang_in;
            zero_ff <= (x_ff == '0) && (y_ff == '0);
         end
         OP_ITER: begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            ang_ff <= ang_in;
         end
         OP_PLO: begin
            prod_ff <= mul_p;
         end
         OP_PHI: begin
            prod_acc_ff <= ACW'(prod_ff) + RND48;
            prod_ff     <= mul_p;
         end
         OP_PSUM: begin
            prod_acc_ff <= prod_acc_ff + (ACW'(prod_ff) <<< 17);
         end
         OP_ANG: begin
            diff_ff <= DW'(signed'(prod_acc_ff[ACW-1:48])) + DW'(angle_offset_ff)
                       - DW'(tilt_ff);
         end
         OP_TMUL: begin
            prod_ff <= mul_p;
         end
         OP_EMIT: begin
            out_rate_ff[0] <= rate_w[0];
            out_rate_ff[1] <= rate_w[1];
            out_rate_ff[2] <= rate_w[2];
            out_acc_ff[0]  <= ax_ff;
            out_acc_ff[1]  <= ay_ff;
            out_acc_ff[2]  <= az_ff;
            out_tilt_ff    <= tilt_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_rate_x    = out_rate_ff[0];
   assign rsp_rate_y    = out_rate_ff[1];
   assign rsp_rate_z    = out_rate_ff[2];
   assign rsp_acc_out_x = out_acc_ff[0];
   assign rsp_acc_out_y = out_acc_ff[1];
   assign rsp_acc_out_z = out_acc_ff[2];
   assign rsp_tilt      = out_tilt_ff;

endmodule

@@ sv/imu_bias_tilt_tracker.sv @@
// Gyro bias tracker and accelerometer tilt filter, top level
//
// Input beats on req_* (valid/ready) carry one frame: func, three accel
// words and three gyro words. Each accepted beat yields one result beat
// on rsp_* (valid/ready) with the three rates, the adjusted accel words
// and the current tilt in Q3.12 radians. Registers are to be written
// through csr_wr_en/csr_index/csr_wdata only while the block is idle;
// the block itself does not enforce this. Measure beats (func 0) skip
// the CORDIC: the frame is loaded, then the result is emitted, and the
// block is ready for the next beat when the result becomes valid.
// Calibrate beats (func 1) run N = min(CORDIC_STEPS, 24) CORDIC steps,
// one micro-rotation per cycle; the bias averages share the multiplier
// during the first six steps, and the angle scale and tilt blend then
// run through PLO, PHI, PSUM, ANG, TMUL and TUPD, of which PLO, PHI and
// TMUL use the multiplier, before the result is emitted.
// A result beat sits in an output register; a new input beat is taken
// while it waits, but the next result holds until the receiver takes it.
// Reset clears the biases and tilt and loads the register defaults.
module imu_bias_tilt_tracker #(
   parameter int CORDIC_STEPS = ibtt_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_rate_x,
   output logic signed [15:0] rsp_rate_y,
   output logic signed [15:0] rsp_rate_z,
   output logic signed [15:0] rsp_acc_out_x,
   output logic signed [15:0] rsp_acc_out_y,
   output logic signed [15:0] rsp_acc_out_z,
   output logic signed [15:0] rsp_tilt,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import ibtt_pkg::*;

   cmd_type cmd;

   ibtt_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ibtt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_func      (req_func),
      .req_accel_x   (req_accel_x),
      .req_accel_y   (req_accel_y),
      .req_accel_z   (req_accel_z),
      .req_gyro_x    (req_gyro_x),
      .req_gyro_y    (req_gyro_y),
      .req_gyro_z    (req_gyro_z),
      .rsp_rate_x    (rsp_rate_x),
      .rsp_rate_y    (rsp_rate_y),
      .rsp_rate_z    (rsp_rate_z),
      .rsp_acc_out_x (rsp_acc_out_x),
      .rsp_acc_out_y (rsp_acc_out_y),
      .rsp_acc_out_z (rsp_acc_out_z),
      .rsp_tilt      (rsp_tilt)
   );

endmodule
